>>> sv/tpis_pkg.sv
package tpis_pkg;

  // Output level range and width
  localparam int LEVEL_W = 7;
  localparam logic [LEVEL_W-1:0] LEVEL_MIN = 7'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;

  // Configuration register map
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_A_X = 3'd0,
    REG_CENTER_A_Y = 3'd1,
    REG_CENTER_B_X = 3'd2,
    REG_CENTER_B_Y = 3'd3,
    REG_CENTER_C_X = 3'd4,
    REG_CENTER_C_Y = 3'd5
  } cfg_reg_t;

  // Reset values of the centre registers, truncated to the coordinate width on use
  localparam logic [15:0] RST_CENTER_A_X = 16'd0;
  localparam logic [15:0] RST_CENTER_A_Y = 16'd120;
  localparam logic [15:0] RST_CENTER_B_X = 16'd0;
  localparam logic [15:0] RST_CENTER_B_Y = 16'd65;
  localparam logic [15:0] RST_CENTER_C_X = 16'd0;
  localparam logic [15:0] RST_CENTER_C_Y = 16'd30;

  // Pipeline control handed to each section: advance enable and entering valid
  typedef struct packed {
    logic en;
    logic valid;
  } stage_ctrl_t;

endpackage

>>> sv/tpis_ifs.sv
interface tpis_pixel_if #(
  parameter int COORD_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface tpis_shade_if;
  logic                         valid;
  logic                         ready;
  logic [tpis_pkg::LEVEL_W-1:0] level;
  logic                         lit;

  modport source (output valid, output level, output lit, input ready);
  modport sink   (input valid, input level, input lit, output ready);
endinterface

interface tpis_cfg_if #(
  parameter int COORD_BITS = 10
);
  logic                           valid;
  logic                           ready;
  logic [tpis_pkg::CFG_IDX_W-1:0] index;
  logic [COORD_BITS-1:0]          data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/three_point_isobar_pixel_shader_unit.sv
// A pixel beat passes the distance, square-root (one root bit per stage) and select sections.
// Throughput: one pixel per cycle while the output is not stalled.
// A stalled output freezes every stage in place, so no beat is lost or repeated.
// Reset (rst, synchronous, active high) clears all valid bits and loads the centre
// registers with their reset values; the pipeline data registers are not reset.
module three_point_isobar_pixel_shader_unit #(
  parameter int COORD_BITS = 10
) (
  input  logic           clk,
  input  logic           rst,
  tpis_pixel_if.sink     pixel_in,
  tpis_shade_if.source   shade_out,
  tpis_cfg_if.sink       cfg
);

  localparam int D2_W   = 2 * COORD_BITS + 1;
  localparam int ROOT_W = COORD_BITS + 1;

  // Centre point registers
  logic [COORD_BITS-1:0] center_a_x, center_a_y;
  logic [COORD_BITS-1:0] center_b_x, center_b_y;
  logic [COORD_BITS-1:0] center_c_x, center_c_y;

  // The whole pipeline advances together; it holds only while the
  // output register carries a beat the sink has not taken.
  logic en;
  tpis_pkg::stage_ctrl_t in_ctrl, sq_ctrl, sq_ctrl_b, sq_ctrl_c, sel_ctrl;

  logic            dv_a, dv_b, dv_c;
  logic [D2_W-1:0] d2_a, d2_b, d2_c;
  logic            rv_a, rv_b, rv_c;
  logic [ROOT_W-1:0] root_a, root_b, root_c;

  assign en             = ~shade_out.valid | shade_out.ready;
  assign pixel_in.ready = en;
  assign cfg.ready      = 1'b1;

  // Configuration beats; an index past the map is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      center_a_x <= COORD_BITS'(tpis_pkg::RST_CENTER_A_X);
      center_a_y <= COORD_BITS'(tpis_pkg::RST_CENTER_A_Y);
      center_b_x <= COORD_BITS'(tpis_pkg::RST_CENTER_B_X);
      center_b_y <= COORD_BITS'(tpis_pkg::RST_CENTER_B_Y);
      center_c_x <= COORD_BITS'(tpis_pkg::RST_CENTER_C_X);
      center_c_y <= COORD_BITS'(tpis_pkg::RST_CENTER_C_Y);
    end else if (cfg.valid) begin
      case (cfg.index)
        tpis_pkg::REG_CENTER_A_X: center_a_x <= cfg.data;
        tpis_pkg::REG_CENTER_A_Y: center_a_y <= cfg.data;
        tpis_pkg::REG_CENTER_B_X: center_b_x <= cfg.data;
        tpis_pkg::REG_CENTER_B_Y: center_b_y <= cfg.data;
        tpis_pkg::REG_CENTER_C_X: center_c_x <= cfg.data;
        tpis_pkg::REG_CENTER_C_Y: center_c_y <= cfg.data;
        default: ;
      endcase
    end
  end

  assign in_ctrl   = '{en: en, valid: pixel_in.valid};
  assign sq_ctrl   = '{en: en, valid: dv_a};
  assign sq_ctrl_b = '{en: en, valid: dv_b};
  assign sq_ctrl_c = '{en: en, valid: dv_c};
  assign sel_ctrl  = '{en: en, valid: rv_a};

  // Squared distance to each centre: difference, square, sum (three stages)
  tpis_dist #(.COORD_BITS(COORD_BITS)) u_dist_a (
    .clk, .rst, .ctrl(in_ctrl),
    .px(pixel_in.pixel_x), .py(pixel_in.pixel_y),
    .cx(center_a_x), .cy(center_a_y),
    .valid_out(dv_a), .d2(d2_a)
  );

  tpis_dist #(.COORD_BITS(COORD_BITS)) u_dist_b (
    .clk, .rst, .ctrl(in_ctrl),
    .px(pixel_in.pixel_x), .py(pixel_in.pixel_y),
    .cx(center_b_x), .cy(center_b_y),
    .valid_out(dv_b), .d2(d2_b)
  );

  tpis_dist #(.COORD_BITS(COORD_BITS)) u_dist_c (
    .clk, .rst, .ctrl(in_ctrl),
    .px(pixel_in.pixel_x), .py(pixel_in.pixel_y),
    .cx(center_c_x), .cy(center_c_y),
    .valid_out(dv_c), .d2(d2_c)
  );

  // Floor square root, one result bit per stage (COORD_BITS + 1 stages)
  tpis_isqrt #(.IN_W(D2_W), .ROOT_W(ROOT_W)) u_isqrt_a (
    .clk, .rst, .ctrl(sq_ctrl), .radicand(d2_a), .valid_out(rv_a), .root(root_a)
  );

  tpis_isqrt #(.IN_W(D2_W), .ROOT_W(ROOT_W)) u_isqrt_b (
    .clk, .rst, .ctrl(sq_ctrl_b), .radicand(d2_b),
    .valid_out(rv_b), .root(root_b)
  );

  tpis_isqrt #(.IN_W(D2_W), .ROOT_W(ROOT_W)) u_isqrt_c (
    .clk, .rst, .ctrl(sq_ctrl_c), .radicand(d2_c),
    .valid_out(rv_c), .root(root_c)
  );

  // Halve, take the minimum, clamp and flag even levels (two stages; the
  // last one is the output register)
  tpis_sel #(.ROOT_W(ROOT_W)) u_sel (
    .clk, .rst, .ctrl(sel_ctrl),
    .root_a, .root_b, .root_c,
    .valid_out(shade_out.valid), .level(shade_out.level), .lit(shade_out.lit)
  );

  // The three distance lanes move in lock step
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    (rv_a == rv_b) && (rv_a == rv_c) && (dv_a == dv_b) && (dv_a == dv_c))
    else $error("distance lanes out of step");

  // A result beat always carries a clamped level
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    shade_out.valid |-> (shade_out.level >= tpis_pkg::LEVEL_MIN) &&
                        (shade_out.level <= tpis_pkg::LEVEL_MAX))
    else $error("level outside clamp range");

  // Lit marks even levels only
  a_lit_even: assert property (@(posedge clk) disable iff (rst)
    shade_out.valid |-> (shade_out.lit == ~shade_out.level[0]))
    else $error("lit does not match level parity");

  // Nothing leaves the block in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !shade_out.valid)
    else $error("result beat right after reset");

endmodule

>>> sv/tpis_dist.sv
module tpis_dist #(
  parameter int COORD_BITS = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  tpis_pkg::stage_ctrl_t     ctrl,
  input  logic [COORD_BITS-1:0]     px,
  input  logic [COORD_BITS-1:0]     py,
  input  logic [COORD_BITS-1:0]     cx,
  input  logic [COORD_BITS-1:0]     cy,
  output logic                      valid_out,
  output logic [2*COORD_BITS:0]     d2
);

  localparam int SQ_W = 2 * COORD_BITS;
  localparam int D2_W = 2 * COORD_BITS + 1;

  logic                  v1, v2, v3;
  logic [COORD_BITS-1:0] dx, dy;
  logic [SQ_W-1:0]       sqx, sqy;
  logic [D2_W-1:0]       sum;

  // Advance the valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (ctrl.en) begin
      v1 <= ctrl.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Absolute differences, then squares, then their sum
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      dx  <= (px >= cx) ? (px - cx) : (cx - px);
      dy  <= (py >= cy) ? (py - cy) : (cy - py);
      sqx <= SQ_W'(dx) * SQ_W'(dx);
      sqy <= SQ_W'(dy) * SQ_W'(dy);
      sum <= D2_W'(sqx) + D2_W'(sqy);
    end
  end

  assign valid_out = v3;
  assign d2        = sum;

endmodule

>>> sv/tpis_isqrt.sv
module tpis_isqrt #(
  parameter int IN_W   = 21,
  parameter int ROOT_W = 11
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tpis_pkg::stage_ctrl_t ctrl,
  input  logic [IN_W-1:0]       radicand,
  output logic                  valid_out,
  output logic [ROOT_W-1:0]     root
);

  // One root bit per stage, most significant first
  localparam int RW = IN_W + 1;

  logic            vld    [ROOT_W];
  logic [IN_W-1:0] rem_q  [ROOT_W];
  logic [RW-1:0]   root_q [ROOT_W];

  genvar i;
  generate
    for (i = 0; i < ROOT_W; i++) begin : g_stage
      localparam logic [RW-1:0] BIT = RW'(1) << (2 * (ROOT_W - 1 - i));

      logic            v_in;
      logic [IN_W-1:0] rem_in;
      logic [RW-1:0]   root_in;
      logic [RW-1:0]   trial;
      logic            take;

      if (i == 0) begin : g_first
        assign v_in    = ctrl.valid;
        assign rem_in  = radicand;
        assign root_in = '0;
      end else begin : g_next
        assign v_in    = vld[i-1];
        assign rem_in  = rem_q[i-1];
        assign root_in = root_q[i-1];
      end

      assign trial = root_in + BIT;
      assign take  = RW'(rem_in) >= trial;

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[i] <= 1'b0;
        end else if (ctrl.en) begin
          vld[i] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (ctrl.en) begin
          rem_q[i]  <= take ? (rem_in - trial[IN_W-1:0]) : rem_in;
          root_q[i] <= take ? ((root_in >> 1) + BIT) : (root_in >> 1);
        end
      end
    end
  endgenerate

  assign valid_out = vld[ROOT_W-1];
  assign root      = root_q[ROOT_W-1][ROOT_W-1:0];

endmodule

>>> sv/tpis_sel.sv
module tpis_sel #(
  parameter int ROOT_W = 11
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tpis_pkg::stage_ctrl_t        ctrl,
  input  logic [ROOT_W-1:0]            root_a,
  input  logic [ROOT_W-1:0]            root_b,
  input  logic [ROOT_W-1:0]            root_c,
  output logic                         valid_out,
  output logic [tpis_pkg::LEVEL_W-1:0] level,
  output logic                         lit
);

  localparam int H_W   = ROOT_W - 1;
  localparam int CMP_W = (H_W > tpis_pkg::LEVEL_W) ? H_W : tpis_pkg::LEVEL_W;

  logic                         v_min, v_out;
  logic [H_W-1:0]               ha, hb, hc, hab, best;
  logic [CMP_W-1:0]             best_w, clamped;
  logic [tpis_pkg::LEVEL_W-1:0] level_q;
  logic                         lit_q;

  // Halve each root and keep the smallest
  assign ha  = root_a[ROOT_W-1:1];
  assign hb  = root_b[ROOT_W-1:1];
  assign hc  = root_c[ROOT_W-1:1];
  assign hab = (hb < ha) ? hb : ha;

  always_comb begin
    best_w = CMP_W'(best);
    if (best_w < CMP_W'(tpis_pkg::LEVEL_MIN)) begin
      clamped = CMP_W'(tpis_pkg::LEVEL_MIN);
    end else if (best_w > CMP_W'(tpis_pkg::LEVEL_MAX)) begin
      clamped = CMP_W'(tpis_pkg::LEVEL_MAX);
    end else begin
      clamped = best_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_min <= 1'b0;
      v_out <= 1'b0;
    end else if (ctrl.en) begin
      v_min <= ctrl.valid;
      v_out <= v_min;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      best    <= (hc < hab) ? hc : hab;
      level_q <= clamped[tpis_pkg::LEVEL_W-1:0];
      lit_q   <= ~clamped[0];
    end
  end

  assign valid_out = v_out;
  assign level     = level_q;
  assign lit       = lit_q;

endmodule

>>> tb/sv/three_point_isobar_pixel_shader_unit_tb.sv
module three_point_isobar_pixel_shader_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS      = 10;
  localparam int COORD_MAX       = (1 << COORD_BITS) - 1;
  // Pixel-to-shade pipeline depth of the unit.
  localparam int PIPE_LATENCY    = COORD_BITS + 6;
  localparam int NUM_CENTER_REGS = 6;
  localparam int IDLE_LIMIT      = 2000;
  localparam int RAND_PER_PHASE  = 90;
  localparam int NUM_PHASES      = 7;
  localparam int RESET_CYCLES    = 11;
  // Largest per-axis offset of a clustered pixel from its centre; a bit past the
  // distance where the level saturates.
  localparam int NEAR_SPREAD     = 230;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } pixel_t;

  typedef struct packed {
    logic [tpis_pkg::LEVEL_W-1:0] level;
    logic                         lit;
  } shade_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tpis_pixel_if #(.COORD_BITS(COORD_BITS)) pixel_in ();
  tpis_shade_if                            shade_out ();
  tpis_cfg_if   #(.COORD_BITS(COORD_BITS)) cfg ();

  three_point_isobar_pixel_shader_unit #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .pixel_in  (pixel_in),
    .shade_out (shade_out),
    .cfg       (cfg)
  );

  // Shadow copy of the centre registers, updated on each accepted cfg beat.
  coord_t center_x [3];
  coord_t center_y [3];

  // Pixels waiting to be driven, and shades predicted for pixels already taken.
  pixel_t pixel_queue [$];
  shade_t shade_expect [$];

  int mismatches      = 0;
  bit src_gaps        = 1'b0;
  bit sink_stalls     = 1'b0;
  int src_gap_left    = 0;
  int sink_stall_left = 0;
  int idle_cycles     = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly back-to-back, some short gaps, an occasional long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Predict the shade of one pixel against the shadow centres: nearest
  // halved floor root distance, clamped to the level range; lit on even.
  function automatic shade_t shade_of(pixel_t p);
    shade_t s;
    longint dx, dy, sq, root, trial, d, best;
    best = -1;
    for (int k = 0; k < 3; k++) begin
      dx = longint'(p.x) - longint'(center_x[k]);
      dy = longint'(p.y) - longint'(center_y[k]);
      sq = dx * dx + dy * dy;
      // Build the root from the top bit down, keeping each bit whose
      // square still fits under the distance.
      root = 0;
      for (int b = 19; b >= 0; b--) begin
        trial = root | (longint'(1) << b);
        if (trial * trial <= sq) root = trial;
      end
      d = root >> 1;
      if (best < 0 || d < best) best = d;
    end
    if (best < longint'(tpis_pkg::LEVEL_MIN)) best = longint'(tpis_pkg::LEVEL_MIN);
    if (best > longint'(tpis_pkg::LEVEL_MAX)) best = longint'(tpis_pkg::LEVEL_MAX);
    s.level = best[tpis_pkg::LEVEL_W-1:0];
    s.lit   = ~best[0];
    return s;
  endfunction

  // Pull a coordinate toward a centre, staying on the raster.
  function automatic coord_t jitter(coord_t c, int spread);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return coord_t'(v);
  endfunction

  task automatic push_pixel(int x, int y);
    pixel_t p;
    p.x = coord_t'(x);
    p.y = coord_t'(y);
    pixel_queue.push_back(p);
  endtask

  // Most random pixels cluster around a centre so the rings and the
  // on-centre case get exercised; the rest are spread over the raster.
  task automatic push_random_pixel();
    pixel_t p;
    int     k;
    int     spread;
    if ($urandom_range(0, 9) < 7) begin
      k      = $urandom_range(0, 2);
      spread = $urandom_range(0, NEAR_SPREAD);
      p.x    = jitter(center_x[k], spread);
      p.y    = jitter(center_y[k], spread);
    end else begin
      p.x = coord_t'($urandom_range(0, COORD_MAX));
      p.y = coord_t'($urandom_range(0, COORD_MAX));
    end
    pixel_queue.push_back(p);
  endtask

  // Write one register; hold valid across back-to-back writes, and now
  // and then drop it between writes. Indexes past the map are ignored.
  task automatic write_reg(logic [tpis_pkg::CFG_IDX_W-1:0] idx, coord_t val);
    cfg.index <= idx;
    cfg.data  <= val;
    cfg.valid <= 1'b1;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      tpis_pkg::REG_CENTER_A_X: center_x[0] = val;
      tpis_pkg::REG_CENTER_A_Y: center_y[0] = val;
      tpis_pkg::REG_CENTER_B_X: center_x[1] = val;
      tpis_pkg::REG_CENTER_B_Y: center_y[1] = val;
      tpis_pkg::REG_CENTER_C_X: center_x[2] = val;
      tpis_pkg::REG_CENTER_C_Y: center_y[2] = val;
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) begin
      cfg.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Write all six centre registers; valid may still be up at the end, and the caller drops it.
  task automatic write_centers(int ax, int ay, int bx, int by, int cx, int cy);
    write_reg(tpis_pkg::REG_CENTER_A_X, coord_t'(ax));
    write_reg(tpis_pkg::REG_CENTER_A_Y, coord_t'(ay));
    write_reg(tpis_pkg::REG_CENTER_B_X, coord_t'(bx));
    write_reg(tpis_pkg::REG_CENTER_B_Y, coord_t'(by));
    write_reg(tpis_pkg::REG_CENTER_C_X, coord_t'(cx));
    write_reg(tpis_pkg::REG_CENTER_C_Y, coord_t'(cy));
  endtask

  // Sample on the falling edge so the check never races the drivers,
  // then let the pipeline drain for its full depth.
  task automatic wait_idle();
    do @(negedge clk);
    while (pixel_queue.size() != 0 || pixel_in.valid || shade_expect.size() != 0);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  // Pixel driver: hold the beat while the unit stalls; on acceptance record
  // the predicted shade, then either idle for a gap or launch the next pixel.
  always @(posedge clk) begin
    pixel_t beat;
    if (rst) begin
      pixel_in.valid <= 1'b0;
      src_gap_left   <= 0;
    end else if (!(pixel_in.valid && !pixel_in.ready)) begin
      if (pixel_in.valid) begin
        beat.x = pixel_in.pixel_x;
        beat.y = pixel_in.pixel_y;
        shade_expect.push_back(shade_of(beat));
      end
      if (src_gap_left > 0) begin
        pixel_in.valid <= 1'b0;
        src_gap_left   <= src_gap_left - 1;
      end else if (pixel_queue.size() != 0) begin
        beat = pixel_queue.pop_front();
        pixel_in.pixel_x <= beat.x;
        pixel_in.pixel_y <= beat.y;
        pixel_in.valid   <= 1'b1;
        src_gap_left     <= src_gaps ? pick_gap() : 0;
      end else begin
        pixel_in.valid <= 1'b0;
      end
    end
  end

  // Shade monitor: compare each accepted beat with the oldest prediction,
  // and throttle ready with random stalls when enabled.
  always @(posedge clk) begin
    shade_t want;
    if (rst) begin
      shade_out.ready <= 1'b0;
      sink_stall_left <= 0;
    end else begin
      if (shade_out.valid && shade_out.ready) begin
        if (shade_expect.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected shade beat, expected none, actual level=%0d lit=%0b",
                   $time, shade_out.level, shade_out.lit);
        end else begin
          want = shade_expect.pop_front();
          if (shade_out.level !== want.level) begin
            mismatches++;
            $display("%0t: level mismatch, expected %0d, actual %0d",
                     $time, want.level, shade_out.level);
          end
          if (shade_out.lit !== want.lit) begin
            mismatches++;
            $display("%0t: lit mismatch, expected %0b, actual %0b",
                     $time, want.lit, shade_out.lit);
          end
        end
      end
      if (sink_stall_left > 0) begin
        shade_out.ready <= 1'b0;
        sink_stall_left <= sink_stall_left - 1;
      end else begin
        shade_out.ready <= 1'b1;
        sink_stall_left <= sink_stalls ? pick_gap() : 0;
      end
    end
  end

  // Watchdog: any beat on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (pixel_in.valid && pixel_in.ready) || (shade_out.valid && shade_out.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
      $display("three_point_isobar_pixel_shader_unit_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // Known values on every input before reset releases.
    pixel_in.valid   = 1'b0;
    pixel_in.pixel_x = '0;
    pixel_in.pixel_y = '0;
    shade_out.ready  = 1'b0;
    cfg.valid        = 1'b0;
    cfg.index        = '0;
    cfg.data         = '0;
    center_x[0] = coord_t'(tpis_pkg::RST_CENTER_A_X);
    center_y[0] = coord_t'(tpis_pkg::RST_CENTER_A_Y);
    center_x[1] = coord_t'(tpis_pkg::RST_CENTER_B_X);
    center_y[1] = coord_t'(tpis_pkg::RST_CENTER_B_Y);
    center_x[2] = coord_t'(tpis_pkg::RST_CENTER_C_X);
    center_y[2] = coord_t'(tpis_pkg::RST_CENTER_C_Y);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // Every phase boundary waits out all pending shades before touching
      // the centres; some phases run with no gaps or stalls at all.
      wait_idle();
      src_gaps    = (phase % 2) == 1;
      sink_stalls = (phase % 3) != 0;
      case (phase)
        0: begin
          // Reset centres: pixels on each centre, the raster corners,
          // tiny distances on both parities, and the clamp boundary.
          push_pixel(int'(tpis_pkg::RST_CENTER_A_X), int'(tpis_pkg::RST_CENTER_A_Y));
          push_pixel(int'(tpis_pkg::RST_CENTER_B_X), int'(tpis_pkg::RST_CENTER_B_Y));
          push_pixel(int'(tpis_pkg::RST_CENTER_C_X), int'(tpis_pkg::RST_CENTER_C_Y));
          push_pixel(0, 0);
          push_pixel(COORD_MAX, COORD_MAX);
          push_pixel(COORD_MAX, 0);
          push_pixel(0, COORD_MAX);
          push_pixel(2, int'(tpis_pkg::RST_CENTER_C_Y));
          push_pixel(4, int'(tpis_pkg::RST_CENTER_C_Y));
          push_pixel(198, int'(tpis_pkg::RST_CENTER_C_Y));
          push_pixel(200, int'(tpis_pkg::RST_CENTER_C_Y));
          push_pixel(202, int'(tpis_pkg::RST_CENTER_C_Y));
          push_pixel(10'h2AA, 10'h155);
          push_pixel(10'h155, 10'h2AA);
        end
        1: begin
          // All centres at the origin; a stray write past the map must not land.
          write_centers(0, 0, 0, 0, 0, 0);
          write_reg(tpis_pkg::CFG_IDX_W'(NUM_CENTER_REGS), coord_t'(COORD_MAX));
          cfg.valid <= 1'b0;
          push_pixel(0, 0);
          push_pixel(COORD_MAX, COORD_MAX);
        end
        2: begin
          // All centres at the far corner.
          write_centers(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
          write_reg(tpis_pkg::CFG_IDX_W'(NUM_CENTER_REGS + 1), '0);
          cfg.valid <= 1'b0;
          push_pixel(COORD_MAX, COORD_MAX);
          push_pixel(0, 0);
          push_pixel(COORD_MAX, 0);
        end
        3: begin
          // Centres on three corners.
          write_centers(0, 0, COORD_MAX, COORD_MAX, 0, COORD_MAX);
          cfg.valid <= 1'b0;
        end
        default: begin
          write_centers($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                        $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                        $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
          write_reg(tpis_pkg::CFG_IDX_W'($urandom_range(NUM_CENTER_REGS,
                                                        (1 << tpis_pkg::CFG_IDX_W) - 1)),
                    coord_t'($urandom_range(0, COORD_MAX)));
          cfg.valid <= 1'b0;
        end
      endcase
      if (phase != 0) begin
        repeat (RAND_PER_PHASE) push_random_pixel();
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("three_point_isobar_pixel_shader_unit_tb: PASS");
    end else begin
      $display("three_point_isobar_pixel_shader_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
